FILE: design/blr_pkg.sv
package blr_pkg;

  localparam int CANVAS_SIZE = 64;
  localparam int COORD_W     = $clog2(CANVAS_SIZE);
  localparam int COLOR_W     = 32;
  // decision term spans roughly -2*major .. +2*minor, plus sign and headroom
  localparam int DEC_W       = COORD_W + 4;

  localparam int IN_BITS  = 4 * COORD_W + COLOR_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 2 * COORD_W + COLOR_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef logic [COORD_W-1:0]        coord_t;
  typedef logic [COLOR_W-1:0]        color_t;
  typedef logic signed [DEC_W-1:0]   dec_t;

  typedef struct packed {
    logic load;
    logic step;
  } blr_cmd_t;

  typedef struct packed {
    logic last;
  } blr_stat_t;

  function automatic dec_t ext_coord(input coord_t v);
    ext_coord = dec_t'({{(DEC_W-COORD_W){1'b0}}, v});
  endfunction

endpackage

FILE: design/blr_ctrl.sv
module blr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  blr_pkg::blr_stat_t stat,
  output blr_pkg::blr_cmd_t  cmd
);
  import blr_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_RUN);
  assign cmd.load = s_tvalid && s_tready;
  assign cmd.step = m_tvalid && m_tready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.load) state_next = ST_RUN;
      end
      ST_RUN: begin
        // drop back once the final pixel word is taken
        if (cmd.step && stat.last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: design/blr_datapath.sv
module blr_datapath (
  input  logic               clk,
  input  blr_pkg::blr_cmd_t  cmd,
  input  blr_pkg::coord_t    start_x,
  input  blr_pkg::coord_t    start_y,
  input  blr_pkg::coord_t    end_x,
  input  blr_pkg::coord_t    end_y,
  input  blr_pkg::color_t    pixel_color,
  output blr_pkg::coord_t    pixel_x,
  output blr_pkg::coord_t    pixel_y,
  output blr_pkg::color_t    out_color,
  output blr_pkg::blr_stat_t stat
);
  import blr_pkg::*;

  // walk registers
  logic   x_major;
  logic   minor_down;
  coord_t maj;
  coord_t maj_end;
  coord_t mnr;
  coord_t dmaj;
  coord_t dmin;
  dec_t   d;
  color_t color;

  // setup terms
  coord_t adx, ady;
  logic   xm_w;
  logic   swap_w;
  coord_t ax_w, ay_w, bx_w, by_w;
  coord_t maj_w, maj_end_w, mnr_w, dmaj_w, dmin_w;
  logic   down_w;
  dec_t   d_init;
  dec_t   d_step;

  always_comb begin
    adx    = (start_x > end_x) ? start_x - end_x : end_x - start_x;
    ady    = (start_y > end_y) ? start_y - end_y : end_y - start_y;
    xm_w   = (ady < adx);
    // start from the smaller coordinate along the major axis
    swap_w = xm_w ? !(start_x < end_x) : !(start_y < end_y);
    ax_w   = swap_w ? end_x : start_x;
    ay_w   = swap_w ? end_y : start_y;
    bx_w   = swap_w ? start_x : end_x;
    by_w   = swap_w ? start_y : end_y;
    if (xm_w) begin
      maj_w     = ax_w;
      maj_end_w = bx_w;
      mnr_w     = ay_w;
      down_w    = (by_w < ay_w);
      dmaj_w    = adx;
      dmin_w    = ady;
    end else begin
      maj_w     = ay_w;
      maj_end_w = by_w;
      mnr_w     = ax_w;
      down_w    = (bx_w < ax_w);
      dmaj_w    = ady;
      dmin_w    = adx;
    end
    d_init = (ext_coord(dmin_w) <<< 1) - ext_coord(dmaj_w);
    if (d > 0) begin
      d_step = d - (ext_coord(dmaj) <<< 1) + (ext_coord(dmin) <<< 1);
    end else begin
      d_step = d + (ext_coord(dmin) <<< 1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_major    <= xm_w;
      minor_down <= down_w;
      maj        <= maj_w;
      maj_end    <= maj_end_w;
      mnr        <= mnr_w;
      dmaj       <= dmaj_w;
      dmin       <= dmin_w;
      d          <= d_init;
      color      <= pixel_color;
    end else if (cmd.step) begin
      // advance one pixel along the major axis
      maj <= maj + coord_t'(1);
      if (d > 0) begin
        mnr <= minor_down ? mnr - coord_t'(1) : mnr + coord_t'(1);
      end
      d <= d_step;
    end
  end

  assign pixel_x   = x_major ? maj : mnr;
  assign pixel_y   = x_major ? mnr : maj;
  assign out_color = color;
  assign stat.last = (maj == maj_end);

endmodule

FILE: design/bresenham_line_rasterizer.sv
// Bresenham line rasterizer.
// Slave stream: one word per line command (two endpoints and a colour).
// Master stream: one word per pixel in walk order; tlast marks the final
// pixel of the line. Every command yields at least one pixel.
// The line walks along x when |dy| < |dx|, otherwise along y, always from
// the endpoint with the smaller major coordinate.
// The first pixel is offered the cycle after the command word is
// taken. Pixels then leave at one per cycle while the receiver takes them.
// The datapath sets up the command when the command word is taken; the walk
// then steps one major coordinate per cycle while the receiver takes pixels.
// A new command is taken only once the final pixel of the previous one has
// gone. When the receiver stalls, the current pixel word holds and the walk
// pauses. Reset returns the block to idle with no pixel pending; a line in
// progress is dropped.
module bresenham_line_rasterizer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // start_x, start_y, end_x, end_y, pixel_color; the word has no pad bits
  input  logic [blr_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // pixel_x, pixel_y, out_color, zero pad
  output logic [blr_pkg::OUT_W-1:0] m_tdata,
  output logic                      m_tlast
);
  import blr_pkg::*;

  blr_cmd_t  cmd;
  blr_stat_t stat;
  coord_t    pixel_x, pixel_y;
  color_t    out_color;

  blr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  blr_datapath u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .start_x     (s_tdata[COORD_W-1:0]),
    .start_y     (s_tdata[2*COORD_W-1:COORD_W]),
    .end_x       (s_tdata[3*COORD_W-1:2*COORD_W]),
    .end_y       (s_tdata[4*COORD_W-1:3*COORD_W]),
    .pixel_color (s_tdata[4*COORD_W+COLOR_W-1:4*COORD_W]),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .out_color   (out_color),
    .stat        (stat)
  );

  assign m_tdata = OUT_W'({out_color, pixel_y, pixel_x});
  assign m_tlast = stat.last;

endmodule

FILE: design/blr_checker.sv
module blr_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [blr_pkg::OUT_W-1:0] m_tdata,
  input logic                      m_tlast
);
  import blr_pkg::*;

  // every command yields a pixel the next cycle
  a_cmd_gives_pixel: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("no pixel after command word");

  // one command at a time
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("command taken while pixels pending");

  // final pixel word ends the line
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
    else $error("pixels continue after last");

  // stalled pixel word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("pixel word changed under stall");

endmodule

bind bresenham_line_rasterizer blr_checker u_blr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

FILE: tb/sv/bresenham_line_rasterizer_test.sv
`timescale 1ns / 1ps

module bresenham_line_rasterizer_test;

  import blr_pkg::*;

  localparam int MAX_COORD = CANVAS_SIZE - 1;

  typedef struct {
    coord_t x;
    coord_t y;
    color_t color;
    logic   last;
  } pixel_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic            m_tlast;

  logic [IN_W-1:0] pending_lines[$];
  pixel_t          expected_pixels[$];
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  int              errors = 0;

  bresenham_line_rasterizer u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  function automatic logic [IN_W-1:0] line_word(int x0, int y0, int x1, int y1, color_t c);
    logic [IN_W-1:0] w;
    w = '0;
    w[COORD_W-1:0]           = coord_t'(x0);
    w[2*COORD_W-1:COORD_W]   = coord_t'(y0);
    w[3*COORD_W-1:2*COORD_W] = coord_t'(x1);
    w[4*COORD_W-1:3*COORD_W] = coord_t'(y1);
    w[4*COORD_W +: COLOR_W]  = c;
    return w;
  endfunction

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > MAX_COORD) return MAX_COORD;
    return v;
  endfunction

  // Walk the line along its major axis and queue one pixel per step.
  task automatic rasterise_line(input logic [IN_W-1:0] w);
    int x0, y0, x1, y1, adx, ady;
    int ax, ay, bx, by, major, minor, dir, dec, m, n;
    bit x_major;
    color_t c;
    pixel_t p;
    x0 = int'(w[COORD_W-1:0]);
    y0 = int'(w[2*COORD_W-1:COORD_W]);
    x1 = int'(w[3*COORD_W-1:2*COORD_W]);
    y1 = int'(w[4*COORD_W-1:3*COORD_W]);
    c  = w[4*COORD_W +: COLOR_W];
    adx = (x0 > x1) ? x0 - x1 : x1 - x0;
    ady = (y0 > y1) ? y0 - y1 : y1 - y0;
    x_major = (ady < adx);
    // put the start on the endpoint with the smaller major coordinate
    if (x_major ? (x0 < x1) : (y0 < y1)) begin
      ax = x0; ay = y0; bx = x1; by = y1;
    end else begin
      ax = x1; ay = y1; bx = x0; by = y0;
    end
    if (x_major) begin
      major = bx - ax; minor = by - ay; n = ay; m = ax;
    end else begin
      major = by - ay; minor = bx - ax; n = ax; m = ay;
    end
    dir = 1;
    if (minor < 0) begin
      dir = -1;
      minor = -minor;
    end
    dec = 2 * minor - major;
    for (int i = 0; i <= major; i++) begin
      p.x     = coord_t'(x_major ? m + i : n);
      p.y     = coord_t'(x_major ? n : m + i);
      p.color = c;
      p.last  = (i == major);
      expected_pixels.push_back(p);
      if (dec > 0) begin
        n   += dir;
        dec -= 2 * major;
      end
      dec += 2 * minor;
    end
  endtask

  task automatic add_random_lines(input int count);
    int x0, y0, x1, y1, kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      x0 = $urandom_range(MAX_COORD);
      y0 = $urandom_range(MAX_COORD);
      if (kind < 55) begin
        x1 = $urandom_range(MAX_COORD);
        y1 = $urandom_range(MAX_COORD);
      end else if (kind < 75) begin
        x1 = clamp_coord(x0 + int'($urandom_range(16)) - 8);
        y1 = clamp_coord(y0 + int'($urandom_range(16)) - 8);
      end else if (kind < 83) begin
        // exact diagonal, either slope
        x1 = $urandom_range(MAX_COORD);
        y1 = clamp_coord(($urandom_range(1) != 0) ? y0 + (x1 - x0) : y0 - (x1 - x0));
        if ((y1 - y0) != (x1 - x0) && (y1 - y0) != (x0 - x1))
          x1 = x0 + ((x1 > x0) ? 1 : -1) * ((y1 > y0) ? y1 - y0 : y0 - y1);
      end else if (kind < 88) begin
        x1 = $urandom_range(MAX_COORD);
        y1 = y0;
      end else if (kind < 93) begin
        x1 = x0;
        y1 = $urandom_range(MAX_COORD);
      end else begin
        x1 = x0;
        y1 = y0;
      end
      pending_lines.push_back(line_word(x0, y0, x1, y1, $urandom));
    end
  endtask

  task automatic wait_drained();
    while (pending_lines.size() != 0 || s_tvalid || expected_pixels.size() != 0)
      @(posedge clk);
  endtask

  // Driver: present the next command word, hold it until taken.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) rasterise_line(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (pending_lines.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tdata  <= pending_lines.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random and check every pixel word taken.
  always @(posedge clk) begin
    pixel_t exp_p;
    coord_t got_x, got_y;
    color_t got_c;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (m_tvalid && m_tready) begin
        got_x = m_tdata[COORD_W-1:0];
        got_y = m_tdata[2*COORD_W-1:COORD_W];
        got_c = m_tdata[2*COORD_W +: COLOR_W];
        if (expected_pixels.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%b",
                   $time, got_x, got_y, got_c, m_tlast);
        end else begin
          exp_p = expected_pixels.pop_front();
          if (got_x !== exp_p.x) begin
            errors++;
            $display("%0t: pixel_x expected %0d got %0d", $time, exp_p.x, got_x);
          end
          if (got_y !== exp_p.y) begin
            errors++;
            $display("%0t: pixel_y expected %0d got %0d", $time, exp_p.y, got_y);
          end
          if (got_c !== exp_p.color) begin
            errors++;
            $display("%0t: out_color expected %h got %h", $time, exp_p.color, got_c);
          end
          if (m_tlast !== exp_p.last) begin
            errors++;
            $display("%0t: last_pixel expected %b got %b", $time, exp_p.last, m_tlast);
          end
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: points, axis lines, diagonals, steep and shallow slopes
    pending_lines.push_back(line_word(0, 0, 0, 0, 32'h0000_0000));
    pending_lines.push_back(line_word(63, 63, 63, 63, 32'hFFFF_FFFF));
    pending_lines.push_back(line_word(0, 0, 63, 0, 32'hAAAA_AAAA));
    pending_lines.push_back(line_word(63, 63, 0, 63, 32'h5555_5555));
    pending_lines.push_back(line_word(0, 0, 0, 63, 32'h1234_5678));
    pending_lines.push_back(line_word(63, 63, 63, 0, 32'h8765_4321));
    pending_lines.push_back(line_word(0, 0, 63, 63, 32'hFFFF_FFFF));
    pending_lines.push_back(line_word(63, 63, 0, 0, 32'h0000_0001));
    pending_lines.push_back(line_word(0, 63, 63, 0, 32'h8000_0000));
    pending_lines.push_back(line_word(63, 0, 0, 63, 32'hDEAD_BEEF));
    pending_lines.push_back(line_word(0, 0, 63, 1, 32'h0F0F_0F0F));
    pending_lines.push_back(line_word(63, 0, 0, 1, 32'hF0F0_F0F0));
    pending_lines.push_back(line_word(0, 0, 1, 63, 32'h00FF_00FF));
    pending_lines.push_back(line_word(1, 0, 0, 63, 32'hFF00_FF00));
    pending_lines.push_back(line_word(0, 0, 63, 62, 32'hCAFE_F00D));
    pending_lines.push_back(line_word(62, 63, 0, 0, 32'h0BAD_CAFE));
    pending_lines.push_back(line_word(10, 20, 40, 5, 32'h1357_9BDF));
    pending_lines.push_back(line_word(40, 5, 10, 20, 32'h2468_ACE0));
    pending_lines.push_back(line_word(5, 40, 20, 10, 32'hA5A5_5A5A));
    pending_lines.push_back(line_word(20, 10, 5, 40, 32'h5A5A_A5A5));
    pending_lines.push_back(line_word(30, 30, 31, 31, 32'h0000_FFFF));
    pending_lines.push_back(line_word(30, 30, 31, 30, 32'hFFFF_0000));
    pending_lines.push_back(line_word(30, 30, 30, 29, 32'h7FFF_FFFF));
    pending_lines.push_back(line_word(63, 0, 0, 0, 32'h0000_0000));
    wait_drained();

    add_random_lines(20);
    wait_drained();

    send_idle_pct = 51;
    add_random_lines(110);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 51;
    add_random_lines(110);
    wait_drained();

    send_idle_pct  = 17;
    recv_stall_pct = 17;
    add_random_lines(110);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    add_random_lines(100);
    wait_drained();

    // let any stray pixel words show up before closing
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("bresenham_line_rasterizer test passed");
    end else begin
      $display("bresenham_line_rasterizer test failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("bresenham_line_rasterizer test failed");
    $finish;
  end

endmodule
